// ===== rtl/core/dec7seg_pkg.sv =====
// Shared types, constants and the digit-to-segment function for the debounced
// encoder counter. Depends on nothing; all files but the button lane use it.
`timescale 1ns / 1ps

package dec7seg_pkg;

    // Field widths.
    localparam int PINS_W     = 8;
    localparam int ENC_PINS_W = 4;
    localparam int COUNT_W    = 14;
    localparam int EVENT_W    = 3;
    localparam int SEG_W      = 8;

    // Default configuration of the lanes.
    localparam int NUM_BUTTONS_DFLT      = 8;
    localparam int NUM_ENCODERS_DFLT     = 2;
    localparam int DEBOUNCE_SAMPLES_DFLT = 12;

    // Count limits and reset values.
    localparam logic [COUNT_W-1:0] MAX_DISPLAY = 14'd9999;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 14'd1023;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd1019;

    // Encoder history patterns, older reading in the upper two bits.
    localparam logic [3:0] ENC_CCW = 4'h0B;
    localparam logic [3:0] ENC_CW  = 4'h07;

    // Event code for a tick without an encoder click.
    localparam logic [EVENT_W-1:0] EVT_NONE = 3'd0;

    // Reciprocal constants for division by 10, 100 and 1000 of values up to 9999.
    localparam int QUOT_PROD_W = 29;
    localparam int RECIP10     = 6554;
    localparam int SHIFT10     = 16;
    localparam int RECIP100    = 10486;
    localparam int SHIFT100    = 20;
    localparam int RECIP1000   = 16778;
    localparam int SHIFT1000   = 24;
    localparam int Q10_W       = 10;
    localparam int Q100_W      = 7;
    localparam int Q1000_W     = 4;

    // Active-low segment codes.
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    // Result of one tick before the display conversion.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PINS_W-1:0]  pulses;
        logic [EVENT_W-1:0] enc_event;
    } tick_t;

    // Decimal digit to active-low segment code.
    function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'b11000000;
            4'd1:    code = 8'b11111001;
            4'd2:    code = 8'b10100100;
            4'd3:    code = 8'b10110000;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/dec7seg_if.sv =====
// Channel interfaces for the pin samples and the display results.
// Depends on dec7seg_pkg for the field widths.
`timescale 1ns / 1ps

interface dec7seg_in_if;
    logic                               valid;
    logic                               ready;
    logic [dec7seg_pkg::PINS_W-1:0]     button_pins;
    logic [dec7seg_pkg::ENC_PINS_W-1:0] encoder_pins;

    modport source (output valid, button_pins, encoder_pins, input ready);
    modport sink (input valid, button_pins, encoder_pins, output ready);
endinterface

interface dec7seg_out_if;
    logic                            valid;
    logic                            ready;
    logic [dec7seg_pkg::COUNT_W-1:0] count_value;
    logic [dec7seg_pkg::PINS_W-1:0]  button_pulses;
    logic [dec7seg_pkg::EVENT_W-1:0] encoder_event;
    logic [dec7seg_pkg::SEG_W-1:0]   seg_ones;
    logic [dec7seg_pkg::SEG_W-1:0]   seg_tens;
    logic [dec7seg_pkg::SEG_W-1:0]   seg_colon;
    logic [dec7seg_pkg::SEG_W-1:0]   seg_hundreds;
    logic [dec7seg_pkg::SEG_W-1:0]   seg_thousands;

    modport source (output valid, count_value, button_pulses, encoder_event, seg_ones,
                    seg_tens, seg_colon, seg_hundreds, seg_thousands, input ready);
    modport sink (input valid, count_value, button_pulses, encoder_event, seg_ones,
                  seg_tens, seg_colon, seg_hundreds, seg_thousands, output ready);
endinterface

// ===== rtl/core/dec7seg_btn_lane.sv =====
// One button lane: sample history shift register and press detection.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps

module dec7seg_btn_lane #(
    parameter int DEBOUNCE_SAMPLES = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic pin,
    output logic pulse
);

    localparam int HIST_W = DEBOUNCE_SAMPLES + 1;
    localparam logic [HIST_W-1:0] HIST_FIRE = {1'b1, {DEBOUNCE_SAMPLES{1'b0}}};

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;

    // Shift the new sample in; a press is one high sample then all lows.
    assign hist_next = {hist_reg[HIST_W-2:0], pin};
    assign pulse     = (hist_next == HIST_FIRE);

    // History update on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (en)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

// ===== rtl/core/dec7seg_enc_lane.sv =====
// One encoder lane: last two A/B readings and click detection.
// Depends on dec7seg_pkg for the click patterns.
`timescale 1ns / 1ps

module dec7seg_enc_lane (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [1:0] ab,
    output logic       ccw,
    output logic       cw
);

    import dec7seg_pkg::*;

    logic [3:0] hist_reg;
    logic [3:0] hist_next;

    // The older reading moves to the upper two bits.
    assign hist_next = {hist_reg[1:0], ab};
    assign ccw       = (hist_next == ENC_CCW);
    assign cw        = (hist_next == ENC_CW);

    // History update on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (en)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

// ===== rtl/core/dec7seg_merge.sv =====
// Merging stage: combines the lane results, reports the encoder event and
// keeps the saturating count. Depends on dec7seg_pkg.
`timescale 1ns / 1ps

module dec7seg_merge #(
    parameter int NUM_BUTTONS  = 8,
    parameter int NUM_ENCODERS = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [dec7seg_pkg::COUNT_W-1:0]     limit,
    input  logic [NUM_BUTTONS-1:0]              pulse_vec,
    input  logic [NUM_ENCODERS-1:0]             ccw_vec,
    input  logic [NUM_ENCODERS-1:0]             cw_vec,
    output dec7seg_pkg::tick_t                  tick_next
);

    import dec7seg_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] limit_eff;
    logic [COUNT_W:0]   stepped;
    logic               up;
    logic               down;
    logic [EVENT_W-1:0] ev_code;
    logic [PINS_W-1:0]  pulses;

    // Button pulses on the port; port bits past the lane count never fire.
    genvar b;
    generate
        for (b = 0; b < PINS_W; b++)
        begin : g_pulse
            if (b < NUM_BUTTONS)
            begin : g_lane
                assign pulses[b] = pulse_vec[b];
            end
            else
            begin : g_none
                assign pulses[b] = 1'b0;
            end
        end
    endgenerate

    // The lowest-numbered encoder with a click names the event.
    always_comb
    begin
        ev_code = EVT_NONE;
        for (int i = NUM_ENCODERS - 1; i >= 0; i--)
        begin
            if (ccw_vec[i])
            begin
                ev_code = EVENT_W'(2 * i + 1);
            end
            else if (cw_vec[i])
            begin
                ev_code = EVENT_W'(2 * i + 2);
            end
        end
    end

    // Net step, floor at zero, then saturation at the effective limit.
    assign up        = |pulse_vec;
    assign down      = (|ccw_vec) | (|cw_vec);
    assign limit_eff = (limit > MAX_DISPLAY) ? MAX_DISPLAY : limit;

    always_comb
    begin
        stepped = {1'b0, count_reg};
        if (up && !down)
        begin
            stepped = {1'b0, count_reg} + 15'd1;
        end
        else if (down && !up && (count_reg != '0))
        begin
            stepped = {1'b0, count_reg} - 15'd1;
        end
        count_next = (stepped > {1'b0, limit_eff}) ? limit_eff : stepped[COUNT_W-1:0];
    end

    assign tick_next.count     = count_next;
    assign tick_next.pulses    = pulses;
    assign tick_next.enc_event = ev_code;

    // Count register, updated on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (en)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/dec7seg_seg_conv.sv =====
// Display conversion: two-stage split of the count into decimal digits and
// the segment output register. Depends on dec7seg_pkg and dec7seg_if.
`timescale 1ns / 1ps

module dec7seg_seg_conv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  dec7seg_pkg::tick_t  tick,
    dec7seg_out_if.source       display
);

    import dec7seg_pkg::*;

    logic                     a_valid_reg;
    logic [COUNT_W-1:0]       a_count_reg;
    logic [PINS_W-1:0]        a_pulses_reg;
    logic [EVENT_W-1:0]       a_event_reg;
    logic [Q10_W-1:0]         q10_reg;
    logic [Q100_W-1:0]        q100_reg;
    logic [Q1000_W-1:0]       q1000_reg;
    logic [QUOT_PROD_W-1:0]   prod10;
    logic [QUOT_PROD_W-1:0]   prod100;
    logic [QUOT_PROD_W-1:0]   prod1000;
    logic                     a_ready;

    logic                     b_valid_reg;
    logic                     b_ready;
    logic [COUNT_W-1:0]       b_count_reg;
    logic [PINS_W-1:0]        b_pulses_reg;
    logic [EVENT_W-1:0]       b_event_reg;
    logic [SEG_W-1:0]         seg_ones_reg;
    logic [SEG_W-1:0]         seg_tens_reg;
    logic [SEG_W-1:0]         seg_hundreds_reg;
    logic [SEG_W-1:0]         seg_thousands_reg;
    logic [3:0]               dig0;
    logic [3:0]               dig1;
    logic [3:0]               dig2;
    logic [3:0]               dig3;

    // Each stage moves when it is empty or the next one takes its item.
    assign b_ready    = !b_valid_reg || display.ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign tick_ready = a_ready;

    // Quotients by 10, 100 and 1000 through reciprocal products.
    assign prod10   = QUOT_PROD_W'(tick.count) * QUOT_PROD_W'(RECIP10);
    assign prod100  = QUOT_PROD_W'(tick.count) * QUOT_PROD_W'(RECIP100);
    assign prod1000 = QUOT_PROD_W'(tick.count) * QUOT_PROD_W'(RECIP1000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && tick_valid)
        begin
            a_count_reg  <= tick.count;
            a_pulses_reg <= tick.pulses;
            a_event_reg  <= tick.enc_event;
            q10_reg      <= prod10[SHIFT10 +: Q10_W];
            q100_reg     <= prod100[SHIFT100 +: Q100_W];
            q1000_reg    <= prod1000[SHIFT1000 +: Q1000_W];
        end
    end

    // Digits as remainders of neighboring quotients.
    assign dig0 = 4'(a_count_reg - COUNT_W'(COUNT_W'(q10_reg) * COUNT_W'(10)));
    assign dig1 = 4'(q10_reg - Q10_W'(Q10_W'(q100_reg) * Q10_W'(10)));
    assign dig2 = 4'(q100_reg - Q100_W'(Q100_W'(q1000_reg) * Q100_W'(10)));
    assign dig3 = q1000_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Segment codes with leading zeros blanked.
    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_count_reg       <= a_count_reg;
            b_pulses_reg      <= a_pulses_reg;
            b_event_reg       <= a_event_reg;
            seg_ones_reg      <= seg_digit(dig0);
            seg_tens_reg      <= (a_count_reg < 14'd10) ? SEG_BLANK : seg_digit(dig1);
            seg_hundreds_reg  <= (a_count_reg < 14'd100) ? SEG_BLANK : seg_digit(dig2);
            seg_thousands_reg <= (a_count_reg < 14'd1000) ? SEG_BLANK : seg_digit(dig3);
        end
    end

    assign display.valid         = b_valid_reg;
    assign display.count_value   = b_count_reg;
    assign display.button_pulses = b_pulses_reg;
    assign display.encoder_event = b_event_reg;
    assign display.seg_ones      = seg_ones_reg;
    assign display.seg_tens      = seg_tens_reg;
    assign display.seg_colon     = SEG_BLANK;
    assign display.seg_hundreds  = seg_hundreds_reg;
    assign display.seg_thousands = seg_thousands_reg;

    // The split must give decimal digits for any count up to the display limit.
    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (dig0 <= 4'd9) && (dig1 <= 4'd9) && (dig2 <= 4'd9)
                        && (dig3 <= 4'd9))
        else $error("digit split out of range");

    // An item in the quotient stage waits while the output stage is held.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_ready) |=> a_valid_reg && $stable(a_count_reg))
        else $error("quotient stage lost its item");

    // A result blanks the thousands digit exactly when the count is below 1000.
    a_blank_thousands: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> ((b_count_reg < 14'd1000) == (seg_thousands_reg == SEG_BLANK)))
        else $error("thousands blanking wrong");

endmodule

// ===== rtl/core/debounced_encoder_counter_7seg.sv =====
// Pin transfers pass the tick, quotient and segment registers to display.
// Throughput: one item per cycle while display is ready; the count register
// closes its loop on each transfer, and the digit split is a two-stage
// reciprocal pipeline. Reset: button and encoder histories clear, the count
// goes to 1019, the limit to 1023, and the pipeline empties.
`timescale 1ns / 1ps

module debounced_encoder_counter_7seg #(
    parameter int NUM_BUTTONS      = dec7seg_pkg::NUM_BUTTONS_DFLT,
    parameter int NUM_ENCODERS     = dec7seg_pkg::NUM_ENCODERS_DFLT,
    parameter int DEBOUNCE_SAMPLES = dec7seg_pkg::DEBOUNCE_SAMPLES_DFLT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            limit_we,
    input  logic [dec7seg_pkg::COUNT_W-1:0] limit_wdata,
    dec7seg_in_if.sink                      pins,
    dec7seg_out_if.source                   display
);

    import dec7seg_pkg::*;

    logic                    accept;
    logic [COUNT_W-1:0]      limit_reg;
    logic [NUM_BUTTONS-1:0]  pulse_vec;
    logic [NUM_ENCODERS-1:0] ccw_vec;
    logic [NUM_ENCODERS-1:0] cw_vec;
    tick_t                   tick_next;
    tick_t                   tick_reg;
    logic                    s1_valid_reg;
    logic                    s1_ready;
    logic                    conv_ready;

    assign s1_ready   = !s1_valid_reg || conv_ready;
    assign pins.ready = s1_ready;
    assign accept     = pins.valid && s1_ready;

    // Limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (limit_we)
        begin
            limit_reg <= limit_wdata;
        end
    end

    // Button lanes; lanes past the pin width see a constant low.
    genvar i;
    generate
        for (i = 0; i < NUM_BUTTONS; i++)
        begin : g_btn
            logic pin;
            if (i < PINS_W)
            begin : g_pin
                assign pin = pins.button_pins[i];
            end
            else
            begin : g_nopin
                assign pin = 1'b0;
            end
            dec7seg_btn_lane #(
                .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
            ) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (accept),
                .pin   (pin),
                .pulse (pulse_vec[i])
            );
        end
    endgenerate

    // Encoder lanes; lanes past the pin width see zeros.
    generate
        for (i = 0; i < NUM_ENCODERS; i++)
        begin : g_enc
            logic [1:0] ab;
            if (2 * i + 1 < ENC_PINS_W)
            begin : g_pin
                assign ab = pins.encoder_pins[2 * i +: 2];
            end
            else
            begin : g_nopin
                assign ab = 2'b00;
            end
            dec7seg_enc_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (accept),
                .ab    (ab),
                .ccw   (ccw_vec[i]),
                .cw    (cw_vec[i])
            );
        end
    endgenerate

    // Merge the lanes and update the count.
    dec7seg_merge #(
        .NUM_BUTTONS  (NUM_BUTTONS),
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .limit     (limit_reg),
        .pulse_vec (pulse_vec),
        .ccw_vec   (ccw_vec),
        .cw_vec    (cw_vec),
        .tick_next (tick_next)
    );

    // Tick register between the count loop and the display pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pins.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= tick_next;
        end
    end

    // Digit split and segment output.
    dec7seg_seg_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (s1_valid_reg),
        .tick_ready (conv_ready),
        .tick       (tick_reg),
        .display    (display)
    );

    // Every transfer lands in the tick register on the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item missing from tick register");

    // The saturated count never exceeds what four digits can show.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (tick_reg.count <= MAX_DISPLAY))
        else $error("count above display limit");

    // A held tick keeps its value until the display pipeline takes it.
    a_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !conv_ready) |=> s1_valid_reg && $stable(tick_reg))
        else $error("tick register changed while stalled");

endmodule

// ===== verif/debounced_encoder_counter_7seg_tb.sv =====
// Self-checking testbench for the debounced encoder counter with its seven-segment readout.
// It depends on dec7seg_pkg, the channel interfaces in dec7seg_if.sv and the block's RTL.
`timescale 1ns / 1ps

module debounced_encoder_counter_7seg_tb;
    import dec7seg_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 150;
    localparam int IDLE_PCT        = 36;
    localparam int NOISE_PCT       = 10;
    localparam int SATURATED_TICKS = 30;
    localparam int ERR_PRINT_MAX   = 40;
    localparam int NUM_BTN         = NUM_BUTTONS_DFLT;
    localparam int NUM_ENC         = NUM_ENCODERS_DFLT;
    localparam int HIST_W          = DEBOUNCE_SAMPLES_DFLT + 1;

    // One released sample followed by a full run of pressed samples.
    localparam logic [HIST_W-1:0] PRESS_SEEN = {1'b1, {DEBOUNCE_SAMPLES_DFLT{1'b0}}};

    // Encoder event codes, lowest-numbered encoder first.
    localparam logic [EVENT_W-1:0] EVT_ONE_CCW = 3'd1;
    localparam logic [EVENT_W-1:0] EVT_ONE_CW  = 3'd2;
    localparam logic [EVENT_W-1:0] EVT_TWO_CCW = 3'd3;
    localparam logic [EVENT_W-1:0] EVT_TWO_CW  = 3'd4;
    localparam logic [NUM_ENC-1:0][EVENT_W-1:0] CCW_CODE = {EVT_TWO_CCW, EVT_ONE_CCW};
    localparam logic [NUM_ENC-1:0][EVENT_W-1:0] CW_CODE  = {EVT_TWO_CW, EVT_ONE_CW};

    // Active-low segment codes for the digits 0 to 9, digit 0 in the lowest slot.
    localparam logic [9:0][SEG_W-1:0] DIGIT_SEG = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                                   8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

    // Quadrature sequence; stepping up turns clockwise.
    localparam logic [3:0][1:0] GRAY_AB = {2'b10, 2'b11, 2'b01, 2'b00};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PINS_W-1:0]  pulses;
        logic [EVENT_W-1:0] evt;
        logic [SEG_W-1:0]   ones;
        logic [SEG_W-1:0]   tens;
        logic [SEG_W-1:0]   colon;
        logic [SEG_W-1:0]   hundreds;
        logic [SEG_W-1:0]   thousands;
    } shown_t;

    typedef enum logic {ROW_TICK, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [COUNT_W-1:0] lim;
        logic [PINS_W-1:0]  bp;
        logic [ENC_PINS_W-1:0] ep;
        int                 reps;
        bit                 typed;
        logic [COUNT_W-1:0] t_count;
        logic [PINS_W-1:0]  t_pulses;
        logic [EVENT_W-1:0] t_evt;
    } plan_row_t;

    // Directed opening: typed values where they follow directly from reset and the pins.
    localparam int PLAN_LEN = 16;
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_TICK,  14'd0,     8'hFF, 4'h0, 1,  1'b1, 14'd1019, 8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'h0, 11, 1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'h0, 1,  1'b1, 14'd1020, 8'hFF, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'h2, 1,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'h3, 1,  1'b1, 14'd1019, 8'h00, EVT_ONE_CCW},
        '{ROW_TICK,  14'd0,     8'h00, 4'h7, 1,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'hF, 1,  1'b1, 14'd1018, 8'h00, EVT_TWO_CW},
        '{ROW_TICK,  14'd0,     8'h00, 4'hA, 1,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'hF, 1,  1'b1, 14'd1017, 8'h00, EVT_ONE_CCW},
        '{ROW_LIMIT, 14'd0,     8'h00, 4'h0, 0,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'hFF, 4'hF, 1,  1'b1, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h55, 4'hA, 1,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'hAA, 4'hF, 1,  1'b1, 14'd0,    8'h00, EVT_ONE_CCW},
        '{ROW_LIMIT, 14'h3FFF,  8'h00, 4'h0, 0,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'h00, 4'h5, 1,  1'b0, 14'd0,    8'h00, EVT_NONE},
        '{ROW_TICK,  14'd0,     8'hFF, 4'hF, 1,  1'b1, 14'd0,    8'h00, EVT_ONE_CW}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                limit_we;
    logic [COUNT_W-1:0]  limit_wdata;

    dec7seg_in_if  pins_if ();
    dec7seg_out_if disp_if ();

    debounced_encoder_counter_7seg u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata),
        .pins        (pins_if),
        .display     (disp_if)
    );

    // Predictor state.
    logic [HIST_W-1:0] hist_btn [NUM_BTN];
    logic [3:0]        hist_enc [NUM_ENC];
    int                count_now;
    int                limit_now;

    // Expected displays, oldest first.
    shown_t shown_q [$];
    shown_t want_now;

    // Random pin generator state.
    bit btn_level [NUM_BTN];
    int btn_left  [NUM_BTN];
    int enc_pos   [NUM_ENC];

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_req  = 1'b0;

    int errors       = 0;
    int checked      = 0;
    int ticks        = 0;
    int ramp_ticks   = 0;
    int limit_writes = 0;
    int cycle_cnt    = 0;

    always #5 clk = ~clk;

    function automatic logic [SEG_W-1:0] seg_of(input int value, input int place);
        if (value < place)
            return SEG_BLANK;
        return DIGIT_SEG[(value / place) % 10];
    endfunction

    // One sampling tick: debounce, quadrature decode, count update and digit split.
    function automatic shown_t count_tick(input logic [PINS_W-1:0] bp,
                                          input logic [ENC_PINS_W-1:0] ep);
        shown_t r;
        int     next;
        int     ceiling;
        r = '0;
        r.evt = EVT_NONE;
        for (int i = 0; i < NUM_BTN; i++)
        begin
            hist_btn[i] = {hist_btn[i][HIST_W-2:0], bp[i]};
            if (hist_btn[i] == PRESS_SEEN)
                r.pulses[i] = 1'b1;
        end
        for (int e = 0; e < NUM_ENC; e++)
        begin
            hist_enc[e] = {hist_enc[e][1:0], ep[2*e +: 2]};
            if (r.evt == EVT_NONE)
            begin
                if (hist_enc[e] == ENC_CCW)
                    r.evt = CCW_CODE[e];
                else if (hist_enc[e] == ENC_CW)
                    r.evt = CW_CODE[e];
            end
        end
        // Net change first, then clamp to zero and to the displayable ceiling.
        next = count_now;
        if (r.pulses != '0)
            next = next + 1;
        if (r.evt != EVT_NONE)
            next = next - 1;
        ceiling = (limit_now > MAX_DISPLAY) ? int'(MAX_DISPLAY) : limit_now;
        if (next < 0)
            next = 0;
        if (next > ceiling)
            next = ceiling;
        count_now = next;
        r.count     = COUNT_W'(next);
        r.ones      = DIGIT_SEG[next % 10];
        r.tens      = seg_of(next, 10);
        r.colon     = SEG_BLANK;
        r.hundreds  = seg_of(next, 100);
        r.thousands = seg_of(next, 1000);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= ERR_PRINT_MAX)
            $display("[%0t] display %0d %s: got 0x%0h, want 0x%0h",
                     $time, checked, what, got, want);
    endtask

    // Offer one pin sample and record its expected display once the transfer happens.
    task automatic offer_pins(input logic [PINS_W-1:0] bp, input logic [ENC_PINS_W-1:0] ep);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            pins_if.valid <= 1'b0;
            @(posedge clk);
        end
        pins_if.valid        <= 1'b1;
        pins_if.button_pins  <= bp;
        pins_if.encoder_pins <= ep;
        @(negedge clk);
        while (!pins_if.ready)
            @(negedge clk);
        @(posedge clk);
        shown_q.push_back(count_tick(bp, ep));
        ticks++;
    endtask

    // The limit is only written once every expected display has come out.
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        pins_if.valid <= 1'b0;
        while (shown_q.size() != 0)
            @(posedge clk);
        limit_we    <= 1'b1;
        limit_wdata <= value;
        @(posedge clk);
        limit_we  <= 1'b0;
        limit_now = int'(value);
        limit_writes++;
    endtask

    // Mostly well-formed presses and quadrature steps, with some noise on top.
    task automatic run_random(input int n);
        logic [PINS_W-1:0]     bp;
        logic [ENC_PINS_W-1:0] ep;
        int                    r;
        repeat (n)
        begin
            for (int i = 0; i < NUM_BTN; i++)
            begin
                // Press runs go both shorter and longer than the debounce window.
                if (btn_left[i] == 0)
                begin
                    btn_level[i] = !btn_level[i];
                    btn_left[i]  = btn_level[i] ? $urandom_range(4, 1) : $urandom_range(20, 1);
                end
                btn_left[i]--;
                bp[i] = btn_level[i];
            end
            for (int e = 0; e < NUM_ENC; e++)
            begin
                r = $urandom_range(9);
                if (r < 4)
                    enc_pos[e] = (enc_pos[e] + 1) % 4;
                else if (r < 8)
                    enc_pos[e] = (enc_pos[e] + 3) % 4;
                ep[2*e +: 2] = GRAY_AB[enc_pos[e]];
            end
            if ($urandom_range(99) < NOISE_PCT)
            begin
                bp = bp ^ PINS_W'($urandom_range(255));
                ep = ENC_PINS_W'($urandom_range(15));
            end
            offer_pins(bp, ep);
        end
    endtask

    // Compare each display transfer with the oldest expectation.
    always @(negedge clk)
    begin
        if (rst_n && disp_if.valid && disp_if.ready)
        begin
            if (shown_q.size() == 0)
                report_mismatch("arrived with nothing expected", 32'(disp_if.count_value),
                                32'd0);
            else
            begin
                want_now = shown_q.pop_front();
                if (disp_if.count_value !== want_now.count)
                    report_mismatch("count_value", 32'(disp_if.count_value),
                                    32'(want_now.count));
                if (disp_if.button_pulses !== want_now.pulses)
                    report_mismatch("button_pulses", 32'(disp_if.button_pulses),
                                    32'(want_now.pulses));
                if (disp_if.encoder_event !== want_now.evt)
                    report_mismatch("encoder_event", 32'(disp_if.encoder_event),
                                    32'(want_now.evt));
                if (disp_if.seg_ones !== want_now.ones)
                    report_mismatch("seg_ones", 32'(disp_if.seg_ones), 32'(want_now.ones));
                if (disp_if.seg_tens !== want_now.tens)
                    report_mismatch("seg_tens", 32'(disp_if.seg_tens), 32'(want_now.tens));
                if (disp_if.seg_colon !== want_now.colon)
                    report_mismatch("seg_colon", 32'(disp_if.seg_colon), 32'(want_now.colon));
                if (disp_if.seg_hundreds !== want_now.hundreds)
                    report_mismatch("seg_hundreds", 32'(disp_if.seg_hundreds),
                                    32'(want_now.hundreds));
                if (disp_if.seg_thousands !== want_now.thousands)
                    report_mismatch("seg_thousands", 32'(disp_if.seg_thousands),
                                    32'(want_now.thousands));
                checked++;
            end
        end
    end

    // Display side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        disp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                disp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            disp_if.ready <= !stalls_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        plan_row_t             row;
        shown_t                pending;
        logic [PINS_W-1:0]     ramp_bp;
        logic [ENC_PINS_W-1:0] ramp_ep;
        int                    t;
        int                    sat_seen;

        rst_n                <= 1'b0;
        limit_we             <= 1'b0;
        limit_wdata          <= '0;
        pins_if.valid        <= 1'b0;
        pins_if.button_pins  <= '0;
        pins_if.encoder_pins <= '0;

        limit_now = int'(LIMIT_RESET);
        count_now = int'(COUNT_RESET);
        foreach (hist_btn[i])
            hist_btn[i] = '0;
        foreach (hist_enc[e])
            hist_enc[e] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening from the table.
        foreach (plan[k])
        begin
            row = plan[k];
            if (row.kind == ROW_LIMIT)
                write_limit(row.lim);
            else
                repeat (row.reps) offer_pins(row.bp, row.ep);
            if (row.typed)
            begin
                pending = shown_q.pop_back();
                pending.count  = row.t_count;
                pending.pulses = row.t_pulses;
                pending.evt    = row.t_evt;
                shown_q.push_back(pending);
            end
        end

        // Wide-open limit, starting from zero.
        run_random(200);

        // Staggered presses without any idling climb the count to a three-digit limit.
        write_limit(14'd150);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        ramp_ep   = ENC_PINS_W'($urandom_range(3) * 5);
        t         = 0;
        sat_seen  = 0;
        while (sat_seen < SATURATED_TICKS)
        begin
            for (int i = 0; i < NUM_BTN; i++)
                ramp_bp[i] = (t % HIST_W == i);
            offer_pins(ramp_bp, ramp_ep);
            if (count_now == limit_now)
                sat_seen++;
            t++;
        end
        ramp_ticks = t;
        gaps_on    = 1'b1;
        stalls_on  = 1'b1;

        // Lower the limit below the count, with a long hold-off on the display side.
        write_limit(14'd100);
        run_random(150);
        hold_req = 1'b1;
        run_random(250);

        // Single-digit limit keeps the count bouncing off zero.
        write_limit(14'd9);
        run_random(200);

        pins_if.valid <= 1'b0;
        while (shown_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d pin samples (%0d in the climb to the limit) over %0d limit settings.",
                 ticks, ramp_ticks, limit_writes + 1);
        $display("Compared %0d displays field by field, %0d mismatches.", checked, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dec7seg_pkg.sv
rtl/core/dec7seg_if.sv
rtl/core/dec7seg_btn_lane.sv
rtl/core/dec7seg_enc_lane.sv
rtl/core/dec7seg_merge.sv
rtl/core/dec7seg_seg_conv.sv
rtl/core/debounced_encoder_counter_7seg.sv
verif/debounced_encoder_counter_7seg_tb.sv
